// ===== rtl/cise_pkg.sv =====
// cise_pkg: shared constants, opcode codes and command/status types
// for the int32 stack execute unit; no dependencies
package cise_pkg;

  localparam int StackDepthDefault = 16;
  localparam int LocalCountDefault = 16;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_UNIMPL = 3'd1;
  localparam logic [2:0] ST_UNDER  = 3'd2;
  localparam logic [2:0] ST_OVER   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_INDEX  = 3'd5;

  localparam logic [1:0] CFG_ARG0  = 2'd0;
  localparam logic [1:0] CFG_ARG1  = 2'd1;
  localparam logic [1:0] CFG_ARG2  = 2'd2;
  localparam logic [1:0] CFG_ARGC  = 2'd3;

  localparam logic [7:0] OP_DIV    = 8'h5B;
  localparam logic [7:0] OP_DIVUN  = 8'h5C;
  localparam logic [7:0] OP_REM    = 8'h5D;
  localparam logic [7:0] OP_REMUN  = 8'h5E;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;   // capture instruction, top two stack reads and local read
    logic execute;    // commit the instruction (non-divide)
    logic div_start;  // start iterative divider
    logic div_commit; // commit divider result
    logic out_load;   // load output register
  } cise_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_div;     // instruction needs the divider and has no error
    logic div_done;
  } cise_stat_t;

endpackage

// ===== rtl/cise_if.sv =====
// cise_if: valid/ready channel carrying a generic payload
// no dependencies
interface cise_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/cise_ctrl.sv =====
// cise_ctrl: sequencing state machine of the execute unit
// depends on cise_pkg
module cise_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  cise_pkg::cise_stat_t stat,
  output cise_pkg::cise_cmd_t  cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0] state, state_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    out_valid_next = out_valid;
    cmd = '0;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.latch_in = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_div) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          cmd.execute = 1'b1;
          cmd.out_load = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_commit = 1'b1;
          cmd.out_load = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.latch_in |=> state == S_EXEC)
    else $error("latch without exec");
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |=> out_valid)
    else $error("result lost");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

// ===== rtl/cise_div.sv =====
// cise_div: radix-2 restoring 32-bit unsigned divider, one bit per cycle
// no dependencies
module cise_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);
  logic [5:0]  count;
  logic        busy;
  logic [31:0] dvs;
  logic [32:0] trial;
  logic [31:0] rem_shift;

  assign rem_shift = {remainder[30:0], quotient[31]};
  assign trial = {remainder, quotient[31]} - {1'b0, dvs};
  assign done = busy && (count == 6'd32);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= '0;
    end else if (busy) begin
      if (count == 6'd32) busy <= 1'b0;
      else count <= count + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      remainder <= '0;
      dvs <= divisor;
    end else if (busy && count != 6'd32) begin
      if (!trial[32]) begin
        remainder <= trial[31:0];
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        remainder <= rem_shift;
        quotient <= {quotient[30:0], 1'b0};
      end
    end
  end
endmodule

// ===== rtl/cise_dp.sv =====
// cise_dp: stack, locals, argument registers, alu and result register
// depends on cise_pkg, cise_div
module cise_dp #(
  parameter int STACK_DEPTH = cise_pkg::StackDepthDefault,
  parameter int LOCAL_COUNT = cise_pkg::LocalCountDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [7:0]          mode,
  input  logic [7:0]          suffix,
  input  logic [31:0]         immediate,
  input  cise_pkg::cise_cmd_t  cmd,
  output cise_pkg::cise_stat_t stat,
  output logic [31:0]         stack_top,
  output logic [4:0]          stack_depth,
  output logic                branch_taken,
  output logic [31:0]         branch_offset,
  output logic                finished,
  output logic [2:0]          status
);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int LAW = $clog2(LOCAL_COUNT);
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

  logic [31:0] arg0, arg1, arg2;
  logic [1:0]  argc;
  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] locals [LOCAL_COUNT];
  logic [LOCAL_COUNT-1:0] loc_valid;
  logic [SPW-1:0] sp;
  logic        halted;
  logic [31:0] top_reg;
  logic [31:0] rd_a, rd_b, rd_l;
  logic [7:0]  m, sfx;
  logic [31:0] imm;

  // stack and local reads, registered at accept
  logic [SPW-1:0] sp_m1, sp_m2;
  logic [7:0]     lidx_in;
  assign sp_m1 = sp - SPW'(1);
  assign sp_m2 = sp - SPW'(2);
  always_comb begin
    if (mode >= 8'h06 && mode <= 8'h09) lidx_in = mode - 8'h06;
    else lidx_in = immediate[7:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      m <= mode;
      sfx <= suffix;
      imm <= immediate;
      rd_a <= stack_mem[sp_m2[SAW-1:0]];
      rd_b <= stack_mem[sp_m1[SAW-1:0]];
      rd_l <= loc_valid[lidx_in[LAW-1:0]] ? locals[lidx_in[LAW-1:0]] : 32'd0;
    end
  end

  // decode and execute
  logic        is_div_op, bin_class, pop1_class;
  logic [2:0]  st;
  logic        fin, taken, do_push, do_pop1_write, do_unary, do_pop2, do_pop1, do_stl;
  logic [31:0] push_v, res, a, b;
  logic        cond;
  logic [7:0]  idx;
  logic [4:0]  sh;
  logic [63:0] prod;

  assign a = rd_a;
  assign b = rd_b;
  assign sh = b[4:0];
  assign prod = a * b;
  assign is_div_op = (m == cise_pkg::OP_DIV) || (m == cise_pkg::OP_DIVUN) ||
                     (m == cise_pkg::OP_REM) || (m == cise_pkg::OP_REMUN);
  assign bin_class = (m >= 8'h2E && m <= 8'h32) || (m >= 8'h58 && m <= 8'h64) ||
                     (m == 8'hFE && (sfx == 8'h01 || sfx == 8'h02 || sfx == 8'h04));

  function automatic logic slt(input logic [31:0] x, input logic [31:0] y);
    slt = $signed(x) < $signed(y);
  endfunction

  always_comb begin
    st = cise_pkg::ST_OK;
    fin = 1'b0; taken = 1'b0; do_push = 1'b0; push_v = imm;
    do_pop1_write = 1'b0; do_unary = 1'b0; do_pop2 = 1'b0; do_pop1 = 1'b0;
    do_stl = 1'b0; res = '0; cond = 1'b0; idx = imm[7:0];
    if (m == 8'h00 || m == 8'h01) begin
    end else if ((m >= 8'h02 && m <= 8'h04) || m == 8'h0E) begin
      idx = (m == 8'h0E) ? imm[7:0] : m - 8'h02;
      if (idx >= {6'd0, argc}) st = cise_pkg::ST_INDEX;
      else if (sp >= SP_FULL) st = cise_pkg::ST_OVER;
      else begin
        do_push = 1'b1;
        push_v = (idx == 8'd0) ? arg0 : (idx == 8'd1) ? arg1 : arg2;
      end
    end else if ((m >= 8'h06 && m <= 8'h09) || m == 8'h11) begin
      idx = (m == 8'h11) ? imm[7:0] : m - 8'h06;
      if ({24'd0, idx} >= LOCAL_COUNT) st = cise_pkg::ST_INDEX;
      else if (sp >= SP_FULL) st = cise_pkg::ST_OVER;
      else begin
        do_push = 1'b1;
        push_v = rd_l;
      end
    end else if ((m >= 8'h0A && m <= 8'h0D) || m == 8'h13) begin
      idx = (m == 8'h13) ? imm[7:0] : m - 8'h0A;
      if (sp == '0) st = cise_pkg::ST_UNDER;
      else if ({24'd0, idx} >= LOCAL_COUNT) st = cise_pkg::ST_INDEX;
      else begin
        do_stl = 1'b1;
        do_pop1 = 1'b1;
      end
    end else if (m >= 8'h15 && m <= 8'h1E) begin
      if (sp >= SP_FULL) st = cise_pkg::ST_OVER;
      else begin
        do_push = 1'b1;
        push_v = {{24{1'b0}}, m - 8'h16};
        push_v = {{24{push_v[7]}}, push_v[7:0]};
      end
    end else if (m == 8'h1F || m == 8'h20) begin
      if (sp >= SP_FULL) st = cise_pkg::ST_OVER;
      else do_push = 1'b1;
    end else if (m == 8'h2A) begin
      fin = 1'b1;
    end else if (m == 8'h2B || m == 8'h38) begin
      taken = 1'b1;
    end else if (m == 8'h2C || m == 8'h2D) begin
      if (sp == '0) st = cise_pkg::ST_UNDER;
      else begin
        do_pop1 = 1'b1;
        taken = ((b != 32'd0) == (m == 8'h2D));
      end
    end else if (bin_class) begin
      if (sp < SPW'(2)) st = cise_pkg::ST_UNDER;
      else if (m <= 8'h32) begin
        do_pop2 = 1'b1;
        case (m)
          8'h2E: cond = (a == b);
          8'h2F: cond = !slt(a, b);
          8'h30: cond = slt(b, a);
          8'h31: cond = !slt(b, a);
          default: cond = slt(a, b);
        endcase
        taken = cond;
      end else if (m == 8'hFE) begin
        do_pop1_write = 1'b1;
        res = {31'd0, (sfx == 8'h01) ? (a == b) : (sfx == 8'h02) ? slt(b, a) : slt(a, b)};
      end else if (is_div_op) begin
        if (b == 32'd0) st = cise_pkg::ST_DIV;
        else if ((m == cise_pkg::OP_DIV || m == cise_pkg::OP_REM) &&
                 a == 32'h8000_0000 && b == 32'hFFFF_FFFF) st = cise_pkg::ST_DIV;
      end else begin
        do_pop1_write = 1'b1;
        case (m)
          8'h58: res = a + b;
          8'h59: res = a - b;
          8'h5A: res = prod[31:0];
          8'h5F: res = a & b;
          8'h60: res = a | b;
          8'h61: res = a ^ b;
          8'h62: res = a << sh;
          8'h63: res = $unsigned($signed(a) >>> sh);
          default: res = a >> sh;
        endcase
      end
    end else if (m == 8'h65 || m == 8'h66) begin
      if (sp == '0) st = cise_pkg::ST_UNDER;
      else begin
        do_unary = 1'b1;
        res = (m == 8'h65) ? 32'd0 - b : ~b;
      end
    end else begin
      st = cise_pkg::ST_UNIMPL;
    end
  end

  assign stat.is_div = !halted && bin_class && is_div_op && sp >= SPW'(2) &&
                       st == cise_pkg::ST_OK;

  // divider on magnitudes
  logic        signed_op, div_q;
  logic [31:0] na, nb, dq, dr, div_res;
  assign signed_op = (m == cise_pkg::OP_DIV) || (m == cise_pkg::OP_REM);
  assign div_q = (m == cise_pkg::OP_DIV) || (m == cise_pkg::OP_DIVUN);
  assign na = (signed_op && a[31]) ? 32'd0 - a : a;
  assign nb = (signed_op && b[31]) ? 32'd0 - b : b;

  cise_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(na), .divisor(nb),
    .done(stat.div_done), .quotient(dq), .remainder(dr)
  );

  always_comb begin
    if (div_q) div_res = (signed_op && (a[31] ^ b[31])) ? 32'd0 - dq : dq;
    else div_res = (signed_op && a[31]) ? 32'd0 - dr : dr;
  end

  // commit
  logic        commit, halt_now;
  logic [SPW-1:0] sp_next;
  logic [31:0] top_next;
  assign commit = cmd.execute && !halted;
  assign halt_now = commit && (st != cise_pkg::ST_OK || fin);

  always_comb begin
    sp_next = sp;
    top_next = top_reg;
    if (cmd.div_commit) begin
      sp_next = sp_m1;
      top_next = div_res;
    end else if (commit) begin
      if (do_push) begin
        sp_next = sp + SPW'(1);
        top_next = push_v;
      end else if (do_pop1_write) begin
        sp_next = sp_m1;
        top_next = res;
      end else if (do_unary) begin
        top_next = res;
      end else if (do_pop1) begin
        sp_next = sp_m1;
        top_next = a;
      end else if (do_pop2) begin
        sp_next = sp_m2;
        top_next = stack_mem[sp_m2[SAW-1:0] - SAW'(1)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_commit) stack_mem[sp_m2[SAW-1:0]] <= div_res;
    else if (commit) begin
      if (do_push) stack_mem[sp[SAW-1:0]] <= push_v;
      else if (do_pop1_write) stack_mem[sp_m2[SAW-1:0]] <= res;
      else if (do_unary) stack_mem[sp_m1[SAW-1:0]] <= res;
    end
    if (commit && do_stl) locals[idx[LAW-1:0]] <= b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
      halted <= 1'b0;
      loc_valid <= '0;
      top_reg <= '0;
      arg0 <= '0; arg1 <= '0; arg2 <= '0; argc <= '0;
    end else begin
      sp <= sp_next;
      top_reg <= top_next;
      if (halt_now) halted <= 1'b1;
      if (commit && do_stl) loc_valid[idx[LAW-1:0]] <= 1'b1;
      if (cfg_we) begin
        unique case (cfg_index)
          cise_pkg::CFG_ARG0: arg0 <= cfg_data;
          cise_pkg::CFG_ARG1: arg1 <= cfg_data;
          cise_pkg::CFG_ARG2: arg2 <= cfg_data;
          cise_pkg::CFG_ARGC: argc <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      stack_top <= (sp_next == '0) ? 32'd0 : top_next;
      stack_depth <= 5'(sp_next);
      branch_taken <= commit && taken;
      branch_offset <= (commit && taken) ? imm : 32'd0;
      finished <= commit && fin;
      status <= commit ? st : cise_pkg::ST_OK;
    end
  end

  assert property (@(posedge clk) disable iff (rst) sp <= SP_FULL)
    else $error("stack pointer out of range");
  assert property (@(posedge clk) disable iff (rst) $past(halted) |-> halted)
    else $error("halt cleared");
  assert property (@(posedge clk) disable iff (rst) halted |-> sp == $past(sp))
    else $error("stack moved while halted");
endmodule

// ===== rtl/cil_int32_stack_execute_unit.sv =====
// cil_int32_stack_execute_unit: top level of the int32 stack execute unit
// depends on cise_pkg, cise_if, cise_ctrl, cise_dp, cise_div
//
// usage:
//   instr channel (sink) carries mode, suffix and immediate; one transaction
//   is one pre-fetched instruction. result channel (source) returns exactly
//   one transaction per instruction: stack top, depth, branch decision and
//   offset, finished flag and status.
//   arguments are written through cfg_we/cfg_index/cfg_data while idle.
// sequencing:
//   accept reads the top two stack entries and the local slot; for all but
//   divides the next cycle commits and loads the result register.
//   div, div.un, rem and rem.un run the bit-serial divider, then commit.
//   one instruction is in flight at a time.
// reset:
//   synchronous; empties the stack, zeroes locals (valid bits) and arguments,
//   clears the halt flag. no clearing pass is needed.
// stall:
//   a waiting result holds in its register; the next instruction is taken as
//   the result leaves.
// after an error or ret the unit halts: later instructions return the stack
// unchanged with status ok until reset.
module cil_int32_stack_execute_unit #(
  parameter int STACK_DEPTH = cise_pkg::StackDepthDefault,
  parameter int LOCAL_COUNT = cise_pkg::LocalCountDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  cise_if.sink        instr,
  cise_if.source      result
);
  cise_pkg::cise_cmd_t  cmd;
  cise_pkg::cise_stat_t stat;

  // control sequencer
  cise_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(instr.valid), .in_ready(instr.ready),
    .out_valid(result.valid), .out_ready(result.ready),
    .stat(stat), .cmd(cmd)
  );

  // datapath: stack, locals, alu, divider and result register
  cise_dp #(.STACK_DEPTH(STACK_DEPTH), .LOCAL_COUNT(LOCAL_COUNT)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mode(instr.payload.mode), .suffix(instr.payload.suffix),
    .immediate(instr.payload.immediate),
    .cmd(cmd), .stat(stat),
    .stack_top(result.payload.stack_top), .stack_depth(result.payload.stack_depth),
    .branch_taken(result.payload.branch_taken),
    .branch_offset(result.payload.branch_offset),
    .finished(result.payload.finished), .status(result.payload.status)
  );
endmodule

// ===== verif/cise_tb_pkg.sv =====
`timescale 1ns / 1ps
// cise_tb_pkg: transaction types and opcode names for the stack execute unit bench
// depends on cise_pkg
package cise_tb_pkg;
  import cise_pkg::*;

  typedef struct packed {
    logic [7:0]  mode;
    logic [7:0]  suffix;
    logic [31:0] immediate;
  } instr_t;

  typedef struct packed {
    logic [31:0] stack_top;
    logic [4:0]  stack_depth;
    logic        branch_taken;
    logic [31:0] branch_offset;
    logic        finished;
    logic [2:0]  status;
  } result_t;

  localparam logic [7:0] OP_NOP     = 8'h00;
  localparam logic [7:0] OP_BREAK   = 8'h01;
  localparam logic [7:0] OP_LDARG0  = 8'h02;
  localparam logic [7:0] OP_LDARG2  = 8'h04;
  localparam logic [7:0] OP_LDLOC0  = 8'h06;
  localparam logic [7:0] OP_LDLOC3  = 8'h09;
  localparam logic [7:0] OP_STLOC0  = 8'h0A;
  localparam logic [7:0] OP_STLOC3  = 8'h0D;
  localparam logic [7:0] OP_LDARG_S = 8'h0E;
  localparam logic [7:0] OP_LDLOC_S = 8'h11;
  localparam logic [7:0] OP_STLOC_S = 8'h13;
  localparam logic [7:0] OP_LDC_M1  = 8'h15;
  localparam logic [7:0] OP_LDC_8   = 8'h1E;
  localparam logic [7:0] OP_LDC_S   = 8'h1F;
  localparam logic [7:0] OP_LDC     = 8'h20;
  localparam logic [7:0] OP_RET     = 8'h2A;
  localparam logic [7:0] OP_BR_S    = 8'h2B;
  localparam logic [7:0] OP_BRFALSE = 8'h2C;
  localparam logic [7:0] OP_BRTRUE  = 8'h2D;
  localparam logic [7:0] OP_BEQ     = 8'h2E;
  localparam logic [7:0] OP_BGE     = 8'h2F;
  localparam logic [7:0] OP_BGT     = 8'h30;
  localparam logic [7:0] OP_BLE     = 8'h31;
  localparam logic [7:0] OP_BLT     = 8'h32;
  localparam logic [7:0] OP_BR      = 8'h38;
  localparam logic [7:0] OP_ADD     = 8'h58;
  localparam logic [7:0] OP_SUB     = 8'h59;
  localparam logic [7:0] OP_MUL     = 8'h5A;
  localparam logic [7:0] OP_AND     = 8'h5F;
  localparam logic [7:0] OP_OR      = 8'h60;
  localparam logic [7:0] OP_XOR     = 8'h61;
  localparam logic [7:0] OP_SHL     = 8'h62;
  localparam logic [7:0] OP_SHR     = 8'h63;
  localparam logic [7:0] OP_SHRUN   = 8'h64;
  localparam logic [7:0] OP_NEG     = 8'h65;
  localparam logic [7:0] OP_NOT     = 8'h66;
  localparam logic [7:0] OP_UNDEF   = 8'hA0;
  localparam logic [7:0] OP_PREFIX  = 8'hFE;

  localparam logic [7:0] SFX_CEQ    = 8'h01;
  localparam logic [7:0] SFX_CGT    = 8'h02;
  localparam logic [7:0] SFX_UNDEF  = 8'h03;
  localparam logic [7:0] SFX_CLT    = 8'h04;

  localparam int NUM_SLOTS = 16;
endpackage

// ===== verif/cise_checker.sv =====
`timescale 1ns / 1ps
// cise_checker: predicts each result of the stack execute unit and compares
// depends on cise_pkg, cise_tb_pkg
module cise_checker
  import cise_pkg::*;
  import cise_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  instr_t      in_item,
  input  logic        out_valid,
  input  logic        out_ready,
  input  result_t     out_item,
  output int          errors,
  output int          pending,
  output int          checked
);
  logic [31:0] stk [NUM_SLOTS];
  logic [31:0] locs [NUM_SLOTS];
  logic [4:0]  sp;
  logic        halted;
  logic [31:0] args [3];
  logic [1:0]  argc;
  result_t     expected_q [$];

  assign pending = expected_q.size();

  function automatic logic [2:0] push(logic [31:0] v);
    if (sp >= NUM_SLOTS) return ST_OVER;
    stk[sp[3:0]] = v;
    sp++;
    return ST_OK;
  endfunction

  function automatic logic [2:0] load_arg(logic [7:0] idx);
    if (idx >= argc) return ST_INDEX;
    return push(args[idx[1:0]]);
  endfunction

  function automatic logic [2:0] load_local(logic [7:0] idx);
    if (idx >= NUM_SLOTS) return ST_INDEX;
    return push(locs[idx[3:0]]);
  endfunction

  function automatic logic [2:0] store_local(logic [7:0] idx);
    if (sp < 1) return ST_UNDER;
    if (idx >= NUM_SLOTS) return ST_INDEX;
    sp--;
    locs[idx[3:0]] = stk[sp[3:0]];
    return ST_OK;
  endfunction

  function automatic logic [2:0] arith(logic [7:0] m, logic [31:0] a, logic [31:0] b,
                                       output logic [31:0] r);
    logic [4:0] sh;
    sh = b[4:0];
    r = '0;
    case (m)
      OP_ADD:   r = a + b;
      OP_SUB:   r = a - b;
      OP_MUL:   r = a * b;
      OP_DIV, OP_REM: begin
        if (b == 0 || (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)) return ST_DIV;
        r = (m == OP_DIV) ? $signed(a) / $signed(b) : $signed(a) % $signed(b);
      end
      OP_DIVUN, OP_REMUN: begin
        if (b == 0) return ST_DIV;
        r = (m == OP_DIVUN) ? a / b : a % b;
      end
      OP_AND:   r = a & b;
      OP_OR:    r = a | b;
      OP_XOR:   r = a ^ b;
      OP_SHL:   r = a << sh;
      OP_SHR:   r = $signed(a) >>> sh;
      default:  r = a >> sh;
    endcase
    return ST_OK;
  endfunction

  function automatic result_t execute(instr_t it);
    result_t     res;
    logic [7:0]  m, s, idx;
    logic [31:0] imm, a, b, v;
    logic [2:0]  st;
    logic        fin, cond, is_br;
    m = it.mode;
    s = it.suffix;
    imm = it.immediate;
    idx = imm[7:0];
    st = ST_OK;
    fin = 1'b0;
    cond = 1'b0;
    is_br = 1'b0;
    if (!halted) begin
      if (m == OP_NOP || m == OP_BREAK) begin
      end else if (m >= OP_LDARG0 && m <= OP_LDARG2) begin
        st = load_arg(m - OP_LDARG0);
      end else if (m == OP_LDARG_S) begin
        st = load_arg(idx);
      end else if (m >= OP_LDLOC0 && m <= OP_LDLOC3) begin
        st = load_local(m - OP_LDLOC0);
      end else if (m == OP_LDLOC_S) begin
        st = load_local(idx);
      end else if (m >= OP_STLOC0 && m <= OP_STLOC3) begin
        st = store_local(m - OP_STLOC0);
      end else if (m == OP_STLOC_S) begin
        st = store_local(idx);
      end else if (m >= OP_LDC_M1 && m <= OP_LDC_8) begin
        st = push(32'(m - OP_LDC_M1) - 32'd1);
      end else if (m == OP_LDC_S || m == OP_LDC) begin
        st = push(imm);
      end else if (m == OP_RET) begin
        fin = 1'b1;
      end else if (m == OP_BR_S || m == OP_BR) begin
        is_br = 1'b1;
        cond = 1'b1;
      end else if (m == OP_BRFALSE || m == OP_BRTRUE) begin
        if (sp < 1) st = ST_UNDER;
        else begin
          sp--;
          cond = (stk[sp[3:0]] != 0) == (m == OP_BRTRUE);
          is_br = 1'b1;
        end
      end else if ((m >= OP_BEQ && m <= OP_BLT) || (m >= OP_ADD && m <= OP_SHRUN) ||
                   (m == OP_PREFIX && (s == SFX_CEQ || s == SFX_CGT || s == SFX_CLT))) begin
        if (sp < 2) st = ST_UNDER;
        else begin
          a = stk[4'(sp - 5'd2)];
          b = stk[4'(sp - 5'd1)];
          if (m >= OP_ADD) begin
            if (m == OP_PREFIX)
              v = (s == SFX_CEQ) ? 32'(a == b) :
                  (s == SFX_CGT) ? 32'($signed(a) > $signed(b)) :
                                   32'($signed(a) < $signed(b));
            else
              st = arith(m, a, b, v);
            if (st == ST_OK) begin
              sp--;
              stk[4'(sp - 5'd1)] = v;
            end
          end else begin
            sp -= 5'd2;
            is_br = 1'b1;
            case (m)
              OP_BEQ:  cond = (a == b);
              OP_BGE:  cond = $signed(a) >= $signed(b);
              OP_BGT:  cond = $signed(a) > $signed(b);
              OP_BLE:  cond = $signed(a) <= $signed(b);
              default: cond = $signed(a) < $signed(b);
            endcase
          end
        end
      end else if (m == OP_NEG || m == OP_NOT) begin
        if (sp < 1) st = ST_UNDER;
        else begin
          a = stk[4'(sp - 5'd1)];
          stk[4'(sp - 5'd1)] = (m == OP_NEG) ? -a : ~a;
        end
      end else begin
        st = ST_UNIMPL;
      end
      if (st != ST_OK || fin) halted = 1'b1;
    end
    res.stack_top     = (sp != 0) ? stk[4'(sp - 5'd1)] : '0;
    res.stack_depth   = sp;
    res.branch_taken  = is_br && cond;
    res.branch_offset = (is_br && cond) ? imm : '0;
    res.finished      = fin;
    res.status        = st;
    return res;
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      sp = '0;
      halted = 1'b0;
      argc = '0;
      foreach (args[i]) args[i] = '0;
      foreach (locs[i]) locs[i] = '0;
      foreach (stk[i]) stk[i] = '0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ARG0: args[0] = cfg_data;
          CFG_ARG1: args[1] = cfg_data;
          CFG_ARG2: args[2] = cfg_data;
          default:  argc = cfg_data[1:0];
        endcase
      end
      if (out_valid && out_ready) begin
        checked++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%t: result with nothing expected: %p", $realtime, out_item);
        end else begin
          e = expected_q.pop_front();
          if (out_item !== e) begin
            errors++;
            if (errors <= 10)
              $display("%t: mismatch\n  expected %p\n  actual   %p", $realtime, e, out_item);
          end
        end
      end
      if (in_valid && in_ready) expected_q.push_back(execute(in_item));
    end
  end

  initial begin
    errors = 0;
    checked = 0;
  end
endmodule

// ===== verif/cil_int32_stack_execute_unit_tb.sv =====
`timescale 1ns / 1ps
// cil_int32_stack_execute_unit_tb: stimulus, back-pressure and verdict for the unit
// depends on cise_pkg, cise_if, cise_tb_pkg, cise_checker and the rtl
module cil_int32_stack_execute_unit_tb;
  import cise_pkg::*;
  import cise_tb_pkg::*;

  localparam int IDLE_LIMIT = 3000;   // cycles with no transaction before giving up
  localparam int PHASE_ITEMS = 150;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors, pending, checked;

  cise_if #(.payload_t(instr_t))  instr_ch ();
  cise_if #(.payload_t(result_t)) result_ch ();

  cil_int32_stack_execute_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .instr     (instr_ch),
    .result    (result_ch)
  );

  cise_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (instr_ch.valid),
    .in_ready  (instr_ch.ready),
    .in_item   (instr_ch.payload),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .out_item  (result_ch.payload),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  // generator view of the machine: stimulus stays legal, so depth is known
  int         depth;
  logic [1:0] arg_count;
  int         sent, divides, settings;
  bit         tx_burst;
  string      ending;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // gap length: mostly none or short, now and then long, none in a burst
  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // values with a bias toward small values and the corners of int32
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return 32'($signed($urandom_range(0, 16)) - 8);
      1: case ($urandom_range(0, 3))
           0: return 32'h8000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 32'h0;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return $urandom;
    endcase
  endfunction

  // stack effect of a legal instruction
  function automatic int depth_change(logic [7:0] m, logic [7:0] s);
    if ((m >= OP_LDARG0 && m <= OP_LDARG2) || m == OP_LDARG_S ||
        (m >= OP_LDLOC0 && m <= OP_LDLOC3) || m == OP_LDLOC_S ||
        (m >= OP_LDC_M1 && m <= OP_LDC) && m != 8'h1F + 8'h2 ) return 1;
    if ((m >= OP_STLOC0 && m <= OP_STLOC3) || m == OP_STLOC_S ||
        m == OP_BRFALSE || m == OP_BRTRUE || (m >= OP_ADD && m <= OP_SHRUN)) return -1;
    if (m == OP_PREFIX && (s == SFX_CEQ || s == SFX_CGT || s == SFX_CLT)) return -1;
    if (m >= OP_BEQ && m <= OP_BLT) return -2;
    return 0;
  endfunction

  // one instruction transaction; valid stays high across back-to-back items
  task automatic send(logic [7:0] m, logic [7:0] s, logic [31:0] imm);
    int gap;
    gap = pick_gap(tx_burst);
    if (gap > 0) begin
      instr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_ch.valid   <= 1'b1;
    instr_ch.payload <= '{mode: m, suffix: s, immediate: imm};
    @(posedge clk);
    while (!instr_ch.ready) @(posedge clk);
    depth += depth_change(m, s);
    sent++;
    if (sent % 50 == 0) tx_burst = ($urandom_range(0, 3) == 0);
  endtask

  task automatic op(logic [7:0] m);
    send(m, 8'($urandom), $urandom);
  endtask

  task automatic op_imm(logic [7:0] m, logic [31:0] imm);
    send(m, 8'($urandom), imm);
  endtask

  // short index forms use only the low byte; the upper bits are noise
  function automatic logic [31:0] short_index(int idx);
    return {24'($urandom), 8'(idx)};
  endfunction

  // pause until the unit has drained, then rewrite all four registers
  task automatic set_args(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2, logic [1:0] cnt);
    logic [1:0]  idx [4];
    logic [31:0] val [4];
    idx = '{CFG_ARG0, CFG_ARG1, CFG_ARG2, CFG_ARGC};
    val = '{a0, a1, a2, 32'(cnt)};
    instr_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    arg_count = cnt;
    settings++;
  endtask

  task automatic push_random();
    int c;
    c = $urandom_range(0, 5);
    if (c == 0 && arg_count == 0) c = 5;
    case (c)
      0: if ($urandom_range(0, 1)) op(OP_LDARG0 + 8'($urandom_range(0, arg_count - 1)));
         else op_imm(OP_LDARG_S, short_index($urandom_range(0, arg_count - 1)));
      1: op(OP_LDLOC0 + 8'($urandom_range(0, 3)));
      2: op_imm(OP_LDLOC_S, short_index($urandom_range(0, NUM_SLOTS - 1)));
      3: op(OP_LDC_M1 + 8'($urandom_range(0, 9)));
      4: op_imm(OP_LDC_S, 32'($signed(8'($urandom))));
      default: op_imm(OP_LDC, rand_word());
    endcase
  endtask

  // only called with at least two entries on the stack
  task automatic consume_random();
    logic [7:0] m;
    case ($urandom_range(0, 9))
      0: op(OP_STLOC0 + 8'($urandom_range(0, 3)));
      1: op_imm(OP_STLOC_S, short_index($urandom_range(0, NUM_SLOTS - 1)));
      2: op_imm($urandom_range(0, 1) ? OP_BRTRUE : OP_BRFALSE, rand_word());
      3: op($urandom_range(0, 1) ? OP_NEG : OP_NOT);
      7: case ($urandom_range(0, 2))
           0: send(OP_PREFIX, SFX_CEQ, $urandom);
           1: send(OP_PREFIX, SFX_CGT, $urandom);
           default: send(OP_PREFIX, SFX_CLT, $urandom);
         endcase
      8: op_imm(OP_BEQ + 8'($urandom_range(0, 4)), rand_word());
      default: begin
        do m = OP_ADD + 8'($urandom_range(0, 12));
        while (m == OP_DIV || m == OP_DIVUN || m == OP_REM || m == OP_REMUN);
        op(m);
      end
    endcase
  endtask

  // divides get a known-safe divisor pushed right before them
  task automatic divide_random();
    logic [31:0] v;
    logic [7:0]  m;
    do v = rand_word();
    while (v == 32'h0 || v == 32'hFFFF_FFFF);
    case ($urandom_range(0, 3))
      0: m = OP_DIV;
      1: m = OP_DIVUN;
      2: m = OP_REM;
      default: m = OP_REMUN;
    endcase
    op_imm(OP_LDC, v);
    op(m);
    divides++;
  endtask

  task automatic random_step();
    int r;
    r = $urandom_range(0, 99);
    if (depth < NUM_SLOTS && (depth < 2 || r < 40)) push_random();
    else if (r < 46) begin
      case ($urandom_range(0, 3))
        0: op(OP_NOP);
        1: op(OP_BREAK);
        2: op_imm(OP_BR_S, rand_word());
        default: op_imm(OP_BR, rand_word());
      endcase
    end else if (depth < NUM_SLOTS && r < 56) divide_random();
    else consume_random();
  endtask

  // one terminating case per run; every later instruction sees a halted unit
  task automatic finish_program();
    int kind;
    kind = $urandom_range(0, 7);
    while (depth > 8) op(OP_STLOC0);
    case (kind)
      0: begin
        ending = "unimplemented opcode";
        if ($urandom_range(0, 1)) op(OP_UNDEF);
        else send(OP_PREFIX, SFX_UNDEF, $urandom);
      end
      1: begin
        ending = "stack underflow";
        while (depth > 0) op(OP_STLOC0);
        if ($urandom_range(0, 1)) op(OP_ADD); else op(OP_NEG);
      end
      2: begin
        ending = "stack overflow";
        while (depth < NUM_SLOTS) op_imm(OP_LDC, rand_word());
        op(OP_LDC_M1);
      end
      3: begin
        ending = "divide by zero";
        op(OP_LDC_M1 + 8'd1);
        op($urandom_range(0, 1) ? OP_REMUN : OP_DIV);
      end
      4: begin
        ending = "minimum divided by minus one";
        op_imm(OP_LDC, 32'h8000_0000);
        op(OP_LDC_M1);
        op($urandom_range(0, 1) ? OP_DIV : OP_REM);
      end
      5: begin
        ending = "local index out of range";
        op_imm($urandom_range(0, 1) ? OP_LDLOC_S : OP_STLOC_S,
               short_index($urandom_range(NUM_SLOTS, 255)));
      end
      6: begin
        ending = "argument index out of range";
        op_imm(OP_LDARG_S, short_index($urandom_range(arg_count, 255)));
      end
      default: begin
        ending = "ret";
        op(OP_RET);
      end
    endcase
    // halted unit: anything goes now
    repeat (12) send(8'($urandom), 8'($urandom), $urandom);
  endtask

  // result side back-pressure, with stall-free stretches
  int  stall_left, rx_count;
  bit  rx_burst;
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
      rx_count = 0;
      rx_burst = 1'b0;
    end else begin
      rx_count++;
      if (rx_count % 400 == 0) rx_burst = ($urandom_range(0, 2) == 0);
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
        if (!rx_burst && $urandom_range(0, 99) < 30) stall_left = pick_gap(1'b0);
      end
    end
  end

  // watchdog on transaction activity
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready) ||
        cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_ARG0;
    cfg_data         <= '0;
    instr_ch.valid   <= 1'b0;
    instr_ch.payload <= '0;
    depth = 0;
    arg_count = 0;
    sent = 0;
    divides = 0;
    settings = 0;
    tx_burst = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: argument and constant extremes, shifts past 31, locals at the edge
    set_args(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 2'd3);
    op(OP_LDARG0);
    op(OP_LDARG0 + 8'd1);
    op(OP_LDARG2);
    op_imm(OP_LDARG_S, short_index(1));
    op_imm(OP_LDC, 32'h7FFF_FFFF);
    op_imm(OP_LDC, 32'h8000_0000);
    op(OP_LDC_M1);
    op(OP_LDC_8);
    op_imm(OP_LDC_S, 32'd33);
    op(OP_SHL);
    op(OP_SHR);
    op(OP_SHRUN);
    op(OP_ADD);
    op(OP_SUB);
    op(OP_MUL);
    op(OP_AND);
    op_imm(OP_STLOC_S, short_index(NUM_SLOTS - 1));
    op_imm(OP_LDLOC_S, short_index(NUM_SLOTS - 1));
    op(OP_LDLOC0);
    send(OP_PREFIX, SFX_CGT, $urandom);
    op_imm(OP_BRTRUE, 32'h8000_0000);
    op(OP_NOP);
    op_imm(OP_BR_S, 32'h7FFF_FFFF);
    op_imm(OP_BR, 32'hFFFF_FFFF);

    // random phases under varied argument settings, both extremes included
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_args($urandom, $urandom, $urandom, 2'd3);
        1: set_args(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 2'd0);
        2: set_args(rand_word(), rand_word(), rand_word(), 2'd1);
        default: set_args($urandom, rand_word(), 32'hFFFF_FFFF, 2'd2);
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) random_step();
    end

    finish_program();
    instr_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("sent %0d instructions (%0d divides) across %0d argument settings",
             sent, divides, settings);
    $display("checked %0d results; program ended by %s", checked, ending);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
